FILE: design/assert_macros.svh
// Assertion macros for the RTL of the temperature display block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion checked on the rising clock edge, ignored while reset is high.
`define TSSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion checked on every rising clock edge, including during reset.
`define TSSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tssm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tssm_pkg;

   typedef enum logic [1:0] {
      ACT_SAMPLE     = 2'd0,
      ACT_CELSIUS    = 2'd1,
      ACT_FAHRENHEIT = 2'd2,
      ACT_TICK       = 2'd3
   } action_type;

   localparam int unsigned SAMPLE_W  = 10;
   localparam int unsigned VALUE_W   = 10;
   localparam int unsigned SEG_W     = 7;
   localparam int unsigned DIGITS    = 3;
   localparam int unsigned INDEX_W   = 2;

   localparam logic [INDEX_W-1:0] LAST_DIGIT = 2'd2;
   localparam logic [VALUE_W-1:0] F_OFFSET   = 10'd32;

   // Segment patterns for decimal digits, bit 0 is segment a.
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
      logic [SEG_W-1:0] pattern;
      case (digit)
         4'd0: pattern = 7'h3F;
         4'd1: pattern = 7'h06;
         4'd2: pattern = 7'h5B;
         4'd3: pattern = 7'h4F;
         4'd4: pattern = 7'h66;
         4'd5: pattern = 7'h6D;
         4'd6: pattern = 7'h7D;
         4'd7: pattern = 7'h07;
         4'd8: pattern = 7'h7F;
         4'd9: pattern = 7'h6F;
         default: pattern = 7'h00;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

FILE: design/tssm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tssm_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     action;
   logic [tssm_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

FILE: design/tssm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tssm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tssm_pkg::SEG_W-1:0]     segments;
   logic [tssm_pkg::DIGITS-1:0]    digit_enable_n;
   logic [tssm_pkg::VALUE_W-1:0]   shown_value;

   modport source (output valid, output segments, output digit_enable_n,
                   output shown_value, input ready);
   modport sink   (input valid, input segments, input digit_enable_n,
                   input shown_value, output ready);
endinterface

`default_nettype wire

FILE: design/tssm_convert.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts a sample to degrees and decodes the digit at the given index.
module tssm_convert (
   input  wire logic [tssm_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                          celsius,
   input  wire logic [tssm_pkg::INDEX_W-1:0]  index,
   output logic      [tssm_pkg::SEG_W-1:0]    segments,
   output logic      [tssm_pkg::DIGITS-1:0]   digit_enable_n,
   output logic      [tssm_pkg::VALUE_W-1:0]  value
);

   logic [19:0] scaled;
   logic [9:0]  quot_est;
   logic [10:0] rem_est;
   logic [9:0]  quot;
   logic [17:0] tens_prod;
   logic [6:0]  tens_all;
   logic [14:0] tens_div_prod;
   logic [3:0]  tens_div;
   logic [15:0] hund_prod;
   logic [3:0]  ones_digit;
   logic [3:0]  tens_digit;
   logic [3:0]  hund_digit;
   logic [3:0]  digit;

   always_comb begin
      if (celsius) begin
         scaled = {10'd0, sample} * 20'd500;
      end else begin
         scaled = {10'd0, sample} * 20'd900;
      end
      // Division by 1023: x = q*1024 + r gives x = q*1023 + (q + r), and
      // q + r stays below 2*1023, so one correction step is enough.
      quot_est = scaled[19:10];
      rem_est  = {1'b0, scaled[9:0]} + {1'b0, quot_est};
      quot     = quot_est + ((rem_est >= 11'd1023) ? 10'd1 : 10'd0);
      value    = celsius ? quot : quot + tssm_pkg::F_OFFSET;
   end

   // Reciprocal multiplies are exact for every value below 1000.
   always_comb begin
      tens_prod     = {8'd0, value} * 18'd205;
      tens_all      = tens_prod[17:11];
      tens_div_prod = {8'd0, tens_all} * 15'd205;
      tens_div      = tens_div_prod[14:11];
      hund_prod     = {6'd0, value} * 16'd41;
      hund_digit    = hund_prod[15:12];
      ones_digit    = 4'(value - {3'd0, tens_all} * 10'd10);
      tens_digit    = 4'(tens_all - {3'd0, tens_div} * 7'd10);
   end

   always_comb begin
      case (index)
         2'd0: begin
            digit          = ones_digit;
            digit_enable_n = 3'b110;
         end
         2'd1: begin
            digit          = tens_digit;
            digit_enable_n = 3'b101;
         end
         2'd2: begin
            digit          = hund_digit;
            digit_enable_n = 3'b011;
         end
         default: begin
            digit          = 4'd0;
            digit_enable_n = 3'b111;
         end
      endcase
      segments = tssm_pkg::seg_pattern(digit);
   end

endmodule

`default_nettype wire

FILE: design/temperature_seven_segment_mux_core.sv
// Temperature display driver for a three-digit multiplexed seven-segment display.
// The req channel carries one event per item: a new 10-bit converter sample,
// select Celsius, select Fahrenheit, or a refresh tick that steps the shown
// digit (ones, tens, hundreds, then back to ones).
// Every event yields exactly one item on the rsp channel: the segment pattern
// of the shown digit, the active-low digit strobes and the converted value,
// all taken from the state as it stands after the event.
// rsp valid rises in the cycle after acceptance; one item is accepted every cycle
// while the receiver takes results, the limit being the single output register.
// A finished item waits in the output register while the receiver stalls; the
// block still accepts a new item in the cycle the waiting item is taken.
// Synchronous reset clears the sample to zero, selects Celsius, points at the
// ones digit and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module temperature_seven_segment_mux_core (
   input  wire logic   clock,
   input  wire logic   reset,
   tssm_req_if.sink    req_ch,
   tssm_rsp_if.source  rsp_ch
);

   logic [tssm_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                          celsius_ff, celsius_in;
   logic [tssm_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic                          rsp_valid_ff;
   logic [tssm_pkg::SEG_W-1:0]    segments_ff;
   logic [tssm_pkg::DIGITS-1:0]   enable_n_ff;
   logic [tssm_pkg::VALUE_W-1:0]  value_ff;
   logic [tssm_pkg::SEG_W-1:0]    segments_in;
   logic [tssm_pkg::DIGITS-1:0]   enable_n_in;
   logic [tssm_pkg::VALUE_W-1:0]  value_in;
   logic                          accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      sample_in  = sample_ff;
      celsius_in = celsius_ff;
      index_in   = index_ff;
      if (accept) begin
         case (tssm_pkg::action_type'(req_ch.action))
            tssm_pkg::ACT_SAMPLE:     sample_in  = req_ch.sample;
            tssm_pkg::ACT_CELSIUS:    celsius_in = 1'b1;
            tssm_pkg::ACT_FAHRENHEIT: celsius_in = 1'b0;
            tssm_pkg::ACT_TICK: begin
               index_in = (index_ff == tssm_pkg::LAST_DIGIT) ? 2'd0 : index_ff + 2'd1;
            end
            default: index_in = index_ff;
         endcase
      end
   end

   tssm_convert u_convert (
      .sample         (sample_in),
      .celsius        (celsius_in),
      .index          (index_in),
      .segments       (segments_in),
      .digit_enable_n (enable_n_in),
      .value          (value_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff    <= '0;
         celsius_ff   <= 1'b1;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sample_ff  <= sample_in;
         celsius_ff <= celsius_in;
         index_ff   <= index_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         segments_ff <= segments_in;
         enable_n_ff <= enable_n_in;
         value_ff    <= value_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.segments       = segments_ff;
   assign rsp_ch.digit_enable_n = enable_n_ff;
   assign rsp_ch.shown_value    = value_ff;

   `TSSM_ASSERT(a_index_range, clock, reset, index_ff != 2'd3, "digit index out of range")
   `TSSM_ASSERT(a_accept_gives_item, clock, reset, accept |=> rsp_valid_ff, "accepted item lost")
   `TSSM_ASSERT(a_value_range, clock, reset, rsp_valid_ff |-> (value_ff <= 10'd932), "value too large")
   `TSSM_ASSERT(a_strobe_matches_index, clock, reset, rsp_valid_ff |-> (enable_n_ff[index_ff] == 1'b0 && $onehot(~enable_n_ff)), "digit strobe disagrees with index")

endmodule

`default_nettype wire

FILE: verif/temperature_display_checker.sv
`timescale 1ns / 1ps

module temperature_display_checker (
   input  logic        clock,
   input  logic        reset,
   tssm_req_if         req_mon,
   tssm_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned backlog
);

   typedef struct packed {
      logic [tssm_pkg::SEG_W-1:0]   segments;
      logic [tssm_pkg::DIGITS-1:0]  digit_enable_n;
      logic [tssm_pkg::VALUE_W-1:0] shown_value;
   } display_word_type;

   display_word_type              expected_words[$];
   logic [tssm_pkg::SAMPLE_W-1:0] held_sample;
   logic                          celsius_selected;
   logic [tssm_pkg::INDEX_W-1:0]  digit_sel;

   function automatic logic [tssm_pkg::SEG_W-1:0] glyph_for(input int unsigned d);
      logic [tssm_pkg::SEG_W-1:0] g;
      case (d)
         0: g = 7'h3F;
         1: g = 7'h06;
         2: g = 7'h5B;
         3: g = 7'h4F;
         4: g = 7'h66;
         5: g = 7'h6D;
         6: g = 7'h7D;
         7: g = 7'h07;
         8: g = 7'h7F;
         default: g = 7'h6F;
      endcase
      return g;
   endfunction

   function automatic display_word_type render_display(
         input logic [tssm_pkg::SAMPLE_W-1:0] s,
         input logic celsius,
         input logic [tssm_pkg::INDEX_W-1:0] idx);
      int unsigned      degrees;
      int unsigned      place;
      display_word_type w;
      if (celsius) begin
         degrees = (int'(s) * 500) / 1023;
      end else begin
         degrees = (int'(s) * 900) / 1023 + 32;
      end
      place = degrees;
      for (int k = 0; k < int'(idx); k++) begin
         place = place / 10;
      end
      w.segments       = glyph_for(place % 10);
      w.digit_enable_n = ~(3'b001 << idx);
      w.shown_value    = degrees[tssm_pkg::VALUE_W-1:0];
      return w;
   endfunction

   always @(posedge clock) begin
      display_word_type              want;
      logic [tssm_pkg::SAMPLE_W-1:0] next_sample;
      logic                          next_celsius;
      logic [tssm_pkg::INDEX_W-1:0]  next_sel;
      if (reset) begin
         held_sample      <= '0;
         celsius_selected <= 1'b1;
         digit_sel        <= '0;
         expected_words.delete();
         mismatch_count   <= 0;
         backlog          <= 0;
      end else begin
         // Results are checked before this edge's item is queued; the result
         // always belongs to an item accepted at an earlier edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: result with no item outstanding: seg %h en %b val %0d",
                           $realtime, rsp_mon.segments, rsp_mon.digit_enable_n,
                           rsp_mon.shown_value);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.segments !== want.segments
                   || rsp_mon.digit_enable_n !== want.digit_enable_n
                   || rsp_mon.shown_value !== want.shown_value) begin
                  if (mismatch_count < 10) begin
                     $display({"%0t: mismatch seg exp %h got %h, en exp %b got %b, ",
                               "val exp %0d got %0d"},
                              $realtime, want.segments, rsp_mon.segments,
                              want.digit_enable_n, rsp_mon.digit_enable_n,
                              want.shown_value, rsp_mon.shown_value);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            next_sample  = held_sample;
            next_celsius = celsius_selected;
            next_sel     = digit_sel;
            case (tssm_pkg::action_type'(req_mon.action))
               tssm_pkg::ACT_SAMPLE:     next_sample  = req_mon.sample;
               tssm_pkg::ACT_CELSIUS:    next_celsius = 1'b1;
               tssm_pkg::ACT_FAHRENHEIT: next_celsius = 1'b0;
               default: begin
                  next_sel = (digit_sel == tssm_pkg::LAST_DIGIT) ? '0 : digit_sel + 1'b1;
               end
            endcase
            held_sample      <= next_sample;
            celsius_selected <= next_celsius;
            digit_sel        <= next_sel;
            expected_words.push_back(render_display(next_sample, next_celsius, next_sel));
         end
         backlog <= expected_words.size();
      end
   end

endmodule

FILE: verif/tb_temperature_seven_segment_mux_core.sv
`timescale 1ns / 1ps

module tb_temperature_seven_segment_mux_core;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned backlog;
   bit          steady_sender;
   bit          steady_receiver;

   tssm_req_if req_if ();
   tssm_rsp_if rsp_if ();

   temperature_seven_segment_mux_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   temperature_display_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .backlog        (backlog)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // Offers one item after a random gap (none while steady_sender is set) and returns at the edge it is taken.
   task automatic offer(input tssm_pkg::action_type act,
                        input logic [tssm_pkg::SAMPLE_W-1:0] smp);
      int unsigned gap;
      gap = steady_sender ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.sample <= smp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   function automatic logic [tssm_pkg::SAMPLE_W-1:0] pick_sample();
      logic [tssm_pkg::SAMPLE_W-1:0] s;
      case ($urandom_range(0, 15))
         0: s = '0;
         1: s = '1;
         2: s = 10'd1;
         3: s = 10'd1022;
         default: s = 10'($urandom_range(0, 1023));
      endcase
      return s;
   endfunction

   // Receiver: random stalls, bursts without stalls, and one long hold-off
   // that fills the output register and backs up the request side.
   initial begin
      int unsigned stall;
      int unsigned taken;
      rsp_if.ready    = 1'b0;
      steady_receiver = 1'b0;
      taken           = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 100 == 0) begin
            steady_receiver = ($urandom_range(0, 3) == 0);
         end
         if (taken == 300) begin
            stall = 200;
         end else begin
            stall = steady_receiver ? 0 : $urandom_range(0, 11);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      tssm_pkg::action_type act;
      int unsigned pick;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.action = tssm_pkg::ACT_SAMPLE;
      req_if.sample = '0;
      steady_sender = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: index wrap, both units at the sample extremes, repeated
      // unit selects, and sample values carried on actions that ignore them.
      offer(tssm_pkg::ACT_TICK, 10'd0);
      offer(tssm_pkg::ACT_TICK, 10'd0);
      offer(tssm_pkg::ACT_TICK, 10'd0);
      offer(tssm_pkg::ACT_SAMPLE, 10'd1023);
      offer(tssm_pkg::ACT_TICK, 10'd0);
      offer(tssm_pkg::ACT_TICK, 10'd0);
      offer(tssm_pkg::ACT_FAHRENHEIT, 10'd0);
      offer(tssm_pkg::ACT_FAHRENHEIT, 10'd1023);
      offer(tssm_pkg::ACT_SAMPLE, 10'd0);
      offer(tssm_pkg::ACT_TICK, 10'd1023);
      offer(tssm_pkg::ACT_TICK, 10'd555);
      offer(tssm_pkg::ACT_SAMPLE, 10'd1022);
      offer(tssm_pkg::ACT_CELSIUS, 10'd777);
      offer(tssm_pkg::ACT_CELSIUS, 10'd5);
      offer(tssm_pkg::ACT_SAMPLE, 10'd512);
      offer(tssm_pkg::ACT_TICK, 10'd1023);
      offer(tssm_pkg::ACT_SAMPLE, 10'd1);
      offer(tssm_pkg::ACT_SAMPLE, 10'h2AA);
      offer(tssm_pkg::ACT_TICK, 10'h155);
      offer(tssm_pkg::ACT_SAMPLE, 10'h155);
      offer(tssm_pkg::ACT_FAHRENHEIT, 10'h3FF);
      offer(tssm_pkg::ACT_SAMPLE, 10'd1023);
      offer(tssm_pkg::ACT_CELSIUS, 10'd0);

      for (int n = 0; n < 1250; n++) begin
         if (n % 100 == 0) begin
            steady_sender = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            act = tssm_pkg::ACT_SAMPLE;
         end else if (pick < 11) begin
            act = tssm_pkg::ACT_CELSIUS;
         end else if (pick < 14) begin
            act = tssm_pkg::ACT_FAHRENHEIT;
         end else begin
            act = tssm_pkg::ACT_TICK;
         end
         offer(act, (act == tssm_pkg::ACT_SAMPLE) ? pick_sample()
                                                  : tssm_pkg::SAMPLE_W'($urandom));
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && backlog == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: temperature_seven_segment_mux_core.f
+incdir+design
design/tssm_pkg.sv
design/tssm_req_if.sv
design/tssm_rsp_if.sv
design/tssm_convert.sv
design/temperature_seven_segment_mux_core.sv
verif/temperature_display_checker.sv
verif/tb_temperature_seven_segment_mux_core.sv
